>>> rtl/bdc_pkg.sv
package bdc_pkg;

    // Widths of the two configuration registers.
    localparam int CFG_W_BITS    = 6;
    localparam int CFG_H_BITS    = 11;
    localparam int CFG_DATA_BITS = 11;

    // Reset values of the configuration registers.
    localparam int CFG_W_RESET = 10;
    localparam int CFG_H_RESET = 10;

    // Depth of the command queue between the front and back ends.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    // Back end sequencer states.
    typedef enum logic [0:0] {
        BACK_RUN   = 1'b0,
        BACK_FLUSH = 1'b1
    } t_back_state;

    // One classified pixel, as handed from the front end to the back end.
    typedef struct packed {
        logic px;        // input pixel
        logic emit;      // pixel produces a result for the row above
        logic up_en;     // row two above is inside the frame
        logic left_en;   // left neighbor is inside the row
        logic right_en;  // right neighbor is inside the row
        logic flush;     // last pixel of the frame
        logic flush_up;  // last row has a row above it
    } t_cmd;

endpackage

>>> rtl/bdc_front.sv
module bdc_front #(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 1024,
    parameter int CW         = 5,
    parameter int RW         = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  bdc_pkg::t_cfg_idx                 i_cfg_index,
    input  logic [bdc_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                              i_push,
    input  logic                              i_pixel_in,
    output bdc_pkg::t_cmd                     o_cmd,
    output logic [CW-1:0]                     o_wm1
);
    import bdc_pkg::*;

    localparam int HB = $clog2(MAX_HEIGHT + 1);
    localparam int HX = ((CFG_H_BITS > HB) ? CFG_H_BITS : HB) + 1;

    logic [CFG_W_BITS-1:0] r_image_width;
    logic [CFG_H_BITS-1:0] r_image_height;
    logic [CW-1:0]         r_col, n_col;
    logic [RW-1:0]         r_row, n_row;
    logic [CW-1:0]         wm1;
    logic [RW-1:0]         hm1;

    // Effective width and height, kept as last column and last row.
    always_comb begin
        if (r_image_width == '0) begin
            wm1 = '0;
        end else if ({1'b0, r_image_width} > (CFG_W_BITS + 1)'(MAX_WIDTH)) begin
            wm1 = CW'(MAX_WIDTH - 1);
        end else begin
            wm1 = CW'(r_image_width - 1'b1);
        end
        if (r_image_height == '0) begin
            hm1 = '0;
        end else if (HX'(r_image_height) > HX'(MAX_HEIGHT)) begin
            hm1 = RW'(MAX_HEIGHT - 1);
        end else begin
            hm1 = RW'(r_image_height - 1'b1);
        end
    end

    // Classify the incoming pixel from its position in the frame.
    always_comb begin
        o_cmd.px       = i_pixel_in;
        o_cmd.emit     = (r_row != '0);
        o_cmd.up_en    = (r_row > RW'(1));
        o_cmd.left_en  = (r_col != '0);
        o_cmd.right_en = (r_col != wm1);
        o_cmd.flush    = (r_col == wm1) && (r_row == hm1);
        o_cmd.flush_up = (r_row != '0);
    end

    assign o_wm1 = wm1;

    // Raster position of the next pixel.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_push) begin
            if (r_col == wm1) begin
                n_col = '0;
                n_row = (r_row == hm1) ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    // Configuration registers; a write restarts the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_W_BITS'(CFG_W_RESET);
            r_image_height <= CFG_H_BITS'(CFG_H_RESET);
            r_col          <= '0;
            r_row          <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[CFG_W_BITS-1:0];
                end
                CFG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data[CFG_H_BITS-1:0];
                end
                default: begin
                    r_image_width <= r_image_width;
                end
            endcase
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

>>> rtl/bdc_queue.sv
module bdc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bdc_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output bdc_pkg::t_cmd o_cmd,
    output logic          o_empty,
    output logic          o_full
);
    import bdc_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0] r_wr;
    logic [QUEUE_PW-1:0] r_rd;
    logic [QUEUE_CW-1:0] r_count;

    assign o_cmd   = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/bdc_back.sv
module bdc_back #(
    parameter int MAX_WIDTH = 32,
    parameter int CW        = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [CW-1:0] i_wm1,
    input  bdc_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output logic          o_pixel_out,
    output logic          o_run_last,
    output logic          o_frame_done
);
    import bdc_pkg::*;

    t_back_state          r_state, n_state;
    logic [CW-1:0]        r_step, n_step;
    logic                 r_flush_up, n_flush_up;
    logic                 r_out_valid, n_out_valid;
    logic                 r_pixel, n_pixel;
    logic                 r_run_last, n_run_last;
    logic                 r_frame_done, n_frame_done;
    logic                 load;
    logic                 shift;
    logic                 shift_in;
    logic                 out_free;
    logic [MAX_WIDTH-1:0] r_line_a, n_line_a;
    logic [MAX_WIDTH-1:0] r_line_b, n_line_b;
    logic [MAX_WIDTH-1:0] a_up, b_up;
    logic                 r_left;

    assign out_free = !r_out_valid || !i_out_stall;

    // Sequencer: one queue entry per cycle unless the output stalls, then the last row on a flush.
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_flush_up   = r_flush_up;
        n_pixel      = r_pixel;
        n_run_last   = r_run_last;
        n_frame_done = r_frame_done;
        load         = 1'b0;
        shift        = 1'b0;
        shift_in     = r_line_a[0];
        o_pop        = 1'b0;
        unique case (r_state)
            BACK_RUN: begin
                if (!i_empty && (!i_cmd.emit || out_free)) begin
                    o_pop    = 1'b1;
                    shift    = 1'b1;
                    shift_in = i_cmd.px;
                    if (i_cmd.emit) begin
                        load         = 1'b1;
                        n_pixel      = r_line_a[0] | i_cmd.px
                                     | (i_cmd.up_en & r_line_b[0])
                                     | (i_cmd.left_en & r_left)
                                     | (i_cmd.right_en & r_line_a[1]);
                        n_run_last   = !i_cmd.flush;
                        n_frame_done = 1'b0;
                    end
                    if (i_cmd.flush) begin
                        n_state    = BACK_FLUSH;
                        n_step     = '0;
                        n_flush_up = i_cmd.flush_up;
                    end
                end
            end
            BACK_FLUSH: begin
                if (out_free) begin
                    shift        = 1'b1;
                    load         = 1'b1;
                    n_pixel      = r_line_a[0]
                                 | (r_flush_up & r_line_b[0])
                                 | ((r_step != '0) & r_left)
                                 | ((r_step != i_wm1) & r_line_a[1]);
                    n_run_last   = (r_step == i_wm1);
                    n_frame_done = (r_step == i_wm1);
                    if (r_step == i_wm1) begin
                        n_state = BACK_RUN;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            default: begin
                n_state = BACK_RUN;
            end
        endcase
    end

    // Output register valid.
    always_comb begin
        if (load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Line shift registers with their entry point at the last column.
    assign a_up = {1'b0, r_line_a[MAX_WIDTH-1:1]};
    assign b_up = {1'b0, r_line_b[MAX_WIDTH-1:1]};

    always_comb begin
        for (int k = 0; k < MAX_WIDTH; k++) begin
            if (CW'(k) == i_wm1) begin
                n_line_a[k] = shift_in;
                n_line_b[k] = r_line_a[0];
            end else begin
                n_line_a[k] = a_up[k];
                n_line_b[k] = b_up[k];
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BACK_RUN;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Line data and result payload.
    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_line_a <= n_line_a;
            r_line_b <= n_line_b;
            r_left   <= r_line_a[0];
        end
        r_flush_up   <= n_flush_up;
        r_pixel      <= n_pixel;
        r_run_last   <= n_run_last;
        r_frame_done <= n_frame_done;
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_out  = r_pixel;
    assign o_run_last   = r_run_last;
    assign o_frame_done = r_frame_done;

endmodule

>>> rtl/binary_dilate_cross3x3.sv
// Binary dilation with a 3x3 cross over a raster-order pixel stream. Each
// result is the center pixel OR its up, down, left and right neighbors,
// with zero outside the frame; result (r-1, c) is formed when the back end
// takes input (r, c) from the queue, and the last input pixel of a frame
// also produces the whole last row, ending with run_last and frame_done
// set. The block takes one pixel per clock while its queue is not full:
// the front end counts columns and rows and classifies each beat, a
// two-entry queue decouples it from the back end, which holds two line
// shift registers and the output register. The last pixel of a frame
// keeps the back end busy emitting the last row, so input stalls there.
// Configuration writes restart the frame and must be made while idle.
module binary_dilate_cross3x3 #(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_pixel_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_pixel_out,
    output logic                              o_run_last,
    output logic                              o_frame_done,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  bdc_pkg::t_cfg_idx                 i_cfg_index,
    input  logic [bdc_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import bdc_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    t_cmd          front_cmd;
    t_cmd          head_cmd;
    logic [CW-1:0] wm1;
    logic          push;
    logic          pop;
    logic          q_empty;
    logic          q_full;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign push        = i_in_valid && !q_full;

    // Position tracking and classification.
    bdc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_pixel_in  (i_pixel_in),
        .o_cmd       (front_cmd),
        .o_wm1       (wm1)
    );

    // Decoupling queue.
    bdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Line buffers, window logic and result output.
    bdc_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wm1        (wm1),
        .i_cmd        (head_cmd),
        .i_empty      (q_empty),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_pixel_out  (o_pixel_out),
        .o_run_last   (o_run_last),
        .o_frame_done (o_frame_done)
    );

endmodule
